// ===== hdl/sbfcp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Start-byte frame checksum parser: shared package
// Payload types, status and register codes, controller states and the
// command and status groups that pass between controller and datapath.
// ---------------------------------------------------------------------------
package sbfcp_pkg;

  // Default for the largest frame the block is built for.
  localparam int MAX_FRAME_DEFAULT = 64;
  // The result index is six bits wide, so no frame holds more than this.
  localparam int STORE_LIMIT = 64;
  // Shortest frame: two sync bytes and the checksum byte.
  localparam int MIN_LEN = 3;
  // Width of the frame length register.
  localparam int LEN_W = 7;
  // Reset value of the frame length register.
  localparam int LEN_RESET = 64;

  typedef enum logic [1:0] {
    ST_FRAME_BYTE = 2'd0,
    ST_CKSUM_ERR  = 2'd1,
    ST_NO_FRAME   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST   = 2'd0,
    REG_SYNC_SECOND  = 2'd1,
    REG_FRAME_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       block_end;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    S_HUNT,
    S_SYNC1,
    S_SECOND,
    S_COLLECT,
    S_DONE,
    S_READ,
    S_COMPARE,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  typedef struct packed {
    logic start_frame;
    logic store_second;
    logic store_byte;
    logic rd_check;
    logic rd_emit;
    logic clr_idx;
    logic inc_idx;
    logic load_noframe;
    logic load_cksum;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic eq_first;
    logic eq_second;
    logic frame_full;
    logic sum_match;
    logic last_idx;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/sbfcp_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Start-byte frame checksum parser: datapath
// Configuration registers, frame store, byte count, running sum, emit
// index and the output register.
// ---------------------------------------------------------------------------
module sbfcp_datapath #(
  parameter int MAX_FRAME = sbfcp_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic [7:0]         rx_byte,
  input  wire sbfcp_pkg::cmd_t    cmd,
  output sbfcp_pkg::stat_t        stat,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output sbfcp_pkg::out_t         out_data
);

  localparam int DEPTH = (MAX_FRAME < sbfcp_pkg::STORE_LIMIT) ? MAX_FRAME
                                                               : sbfcp_pkg::STORE_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = sbfcp_pkg::LEN_W;

  logic [7:0]     sync_first;
  logic [7:0]     sync_second;
  logic [LW-1:0]  frame_length;
  logic [LW-1:0]  len;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             has_room;
  logic [7:0]     sum;
  logic [7:0]     hold;
  logic [AW-1:0]  idx;
  logic [7:0]     store [DEPTH];
  logic [7:0]     rd_data;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [7:0]     mem_wd;
  logic           mem_re;
  logic [AW-1:0]  mem_ra;
  logic           out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= 8'd0;
      sync_second  <= 8'd0;
      frame_length <= LW'(sbfcp_pkg::LEN_RESET);
    end else if (cfg_valid) begin
      case (sbfcp_pkg::cfg_reg_t'(cfg_index))
        sbfcp_pkg::REG_SYNC_FIRST:   sync_first   <= cfg_data;
        sbfcp_pkg::REG_SYNC_SECOND:  sync_second  <= cfg_data;
        sbfcp_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length, clamped between the shortest frame and what the store can hold.
  always_comb begin
    if (frame_length < LW'(sbfcp_pkg::MIN_LEN)) begin
      len = LW'(sbfcp_pkg::MIN_LEN);
    end else if (frame_length > LW'(DEPTH)) begin
      len = LW'(DEPTH);
    end else begin
      len = frame_length;
    end
  end

  assign has_room   = count < CNT_W'(DEPTH);
  assign count_next = has_room ? count + CNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= 8'd0;
    end else if (cmd.start_frame) begin
      count <= CNT_W'(2);
      sum   <= sync_first + rx_byte;
    end else if (cmd.store_byte) begin
      count <= count_next;
      if (has_room && ((LW'(count) + LW'(1)) < len)) begin
        sum <= sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      hold <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + AW'(1);
    end
  end

  // Frame store: one write port, one registered read port.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rx_byte;
    if (cmd.start_frame) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = sync_first;
    end else if (cmd.store_second) begin
      mem_we = 1'b1;
      mem_wa = AW'(1);
      mem_wd = hold;
    end else if (cmd.store_byte && has_room) begin
      mem_we = 1'b1;
      mem_wa = count[AW-1:0];
      mem_wd = rx_byte;
    end
  end

  assign mem_re = cmd.rd_check | cmd.rd_emit;
  assign mem_ra = cmd.rd_check ? AW'(len - LW'(1)) : idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= store[mem_ra];
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.eq_first   = rx_byte == sync_first;
    stat.eq_second  = rx_byte == sync_second;
    stat.frame_full = LW'(count_next) >= len;
    stat.sum_match  = rd_data == sum;
    stat.last_idx   = LW'(idx) == (len - LW'(1));
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_noframe || cmd.load_cksum || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_noframe) begin
      out_data <= '{status: sbfcp_pkg::ST_NO_FRAME, frame_byte: 8'd0,
                    byte_index: 6'd0, last: 1'b1};
    end else if (cmd.load_cksum) begin
      out_data <= '{status: sbfcp_pkg::ST_CKSUM_ERR, frame_byte: 8'd0,
                    byte_index: 6'd0, last: 1'b1};
    end else if (cmd.load_byte) begin
      out_data <= '{status: sbfcp_pkg::ST_FRAME_BYTE, frame_byte: rd_data,
                    byte_index: 6'(idx), last: stat.last_idx};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sbfcp_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Start-byte frame checksum parser: controller
// Sync hunt, frame collection, checksum check and frame read-out sequencing.
// ---------------------------------------------------------------------------
module sbfcp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             block_end,
  input  wire sbfcp_pkg::stat_t stat,
  output sbfcp_pkg::cmd_t       cmd
);

  sbfcp_pkg::state_t state;
  sbfcp_pkg::state_t state_next;
  logic              end_pending;
  logic              accepting;
  logic              acc;
  sbfcp_pkg::state_t after_frame;

  always_comb begin
    case (state)
      sbfcp_pkg::S_HUNT, sbfcp_pkg::S_SYNC1,
      sbfcp_pkg::S_COLLECT, sbfcp_pkg::S_DONE: accepting = 1'b1;
      default: accepting = 1'b0;
    endcase
  end

  assign in_stall    = !(accepting && stat.out_free);
  assign acc         = in_valid && !in_stall;
  assign after_frame = end_pending ? sbfcp_pkg::S_HUNT : sbfcp_pkg::S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sbfcp_pkg::S_HUNT;
      end_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sbfcp_pkg::S_COLLECT && acc && stat.frame_full) begin
        end_pending <= block_end;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbfcp_pkg::S_HUNT: begin
        if (acc && !block_end && stat.eq_first) begin
          state_next = sbfcp_pkg::S_SYNC1;
        end
      end
      sbfcp_pkg::S_SYNC1: begin
        if (acc) begin
          if (block_end) begin
            state_next = sbfcp_pkg::S_HUNT;
          end else if (stat.eq_second) begin
            state_next = sbfcp_pkg::S_SECOND;
          end else if (!stat.eq_first) begin
            state_next = sbfcp_pkg::S_HUNT;
          end
        end
      end
      sbfcp_pkg::S_SECOND: state_next = sbfcp_pkg::S_COLLECT;
      sbfcp_pkg::S_COLLECT: begin
        if (acc) begin
          if (stat.frame_full) begin
            state_next = sbfcp_pkg::S_READ;
          end else if (block_end) begin
            state_next = sbfcp_pkg::S_HUNT;
          end
        end
      end
      sbfcp_pkg::S_DONE: begin
        if (acc && block_end) begin
          state_next = sbfcp_pkg::S_HUNT;
        end
      end
      sbfcp_pkg::S_READ: state_next = sbfcp_pkg::S_COMPARE;
      sbfcp_pkg::S_COMPARE: begin
        if (stat.sum_match) begin
          state_next = sbfcp_pkg::S_EMIT_RD;
        end else if (stat.out_free) begin
          state_next = after_frame;
        end
      end
      sbfcp_pkg::S_EMIT_RD: state_next = sbfcp_pkg::S_EMIT_WR;
      sbfcp_pkg::S_EMIT_WR: begin
        if (stat.out_free) begin
          state_next = stat.last_idx ? after_frame : sbfcp_pkg::S_EMIT_RD;
        end
      end
      default: state_next = sbfcp_pkg::S_HUNT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state)
      sbfcp_pkg::S_HUNT: begin
        cmd.load_noframe = acc && block_end;
      end
      sbfcp_pkg::S_SYNC1: begin
        cmd.load_noframe = acc && block_end;
        cmd.start_frame  = acc && !block_end && stat.eq_second;
      end
      sbfcp_pkg::S_SECOND: begin
        cmd.store_second = 1'b1;
      end
      sbfcp_pkg::S_COLLECT: begin
        cmd.store_byte   = acc;
        cmd.load_noframe = acc && block_end && !stat.frame_full;
      end
      sbfcp_pkg::S_READ: begin
        cmd.rd_check = 1'b1;
      end
      sbfcp_pkg::S_COMPARE: begin
        cmd.clr_idx    = stat.sum_match;
        cmd.load_cksum = !stat.sum_match && stat.out_free;
      end
      sbfcp_pkg::S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
      end
      sbfcp_pkg::S_EMIT_WR: begin
        cmd.load_byte = stat.out_free;
        cmd.inc_idx   = stat.out_free && !stat.last_idx;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/start_byte_frame_checksum_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Start-byte frame checksum parser
// Finds a two-byte sync pair in each receive block, collects a frame of the
// configured length and checks its 8-bit additive checksum.
// ---------------------------------------------------------------------------
// Usage: received bytes enter on the in channel, one transaction per byte,
// with block_end set on the last byte of a receive block. Results leave on
// the out channel: every byte of a good frame in order (last on the final
// byte), one checksum-error transaction for a bad frame, or one no-frame
// transaction when a block ends without a complete frame. Both channels use
// valid and stall; a stall from the receiver holds the output register and,
// once it is full, stalls the input side as well.
// While hunting or collecting, one byte is taken per cycle unless the output
// stalls; after the sync pair the second sync byte is written to the store.
// A no-frame result sits in the output register the cycle after the byte
// that caused it. A completed frame first passes the checksum read and
// compare states, at whose end a checksum-error result is loaded; a good
// frame then has every byte read back through the single registered read
// port of the frame store (a read and a write state each), taking no input.
// The config channel (always ready) sets the sync bytes and the frame length;
// the user must write it only while idle, which the block does not enforce.
// Reset (synchronous, rst high) returns the parser to hunting, restores the
// register defaults and empties the output register; the frame store is not
// cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module start_byte_frame_checksum_parser #(
  parameter int MAX_FRAME = sbfcp_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sbfcp_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sbfcp_pkg::out_t     out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data
);

  // Command and status groups between the sequencer and the datapath.
  sbfcp_pkg::cmd_t  cmd;
  sbfcp_pkg::stat_t stat;

  // The controller owns the protocol phase and the input handshake.
  sbfcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .block_end (in_data.block_end),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the frame store and the output stage.
  sbfcp_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (in_data.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
